@@ sv/ili_pkg.sv @@
// ili_pkg: shared types and codes for the indexed list block
// holds the input and result word structs, command and status codes and the cell control struct
// no dependencies
`timescale 1ns / 1ps

package ili_pkg;

  localparam int unsigned CapacityDefault = 1024;

  // command codes
  localparam logic [2:0] CMD_READ       = 3'd0;
  localparam logic [2:0] CMD_INS_HEAD   = 3'd1;
  localparam logic [2:0] CMD_INS_TAIL   = 3'd2;
  localparam logic [2:0] CMD_INS_AT     = 3'd3;
  localparam logic [2:0] CMD_DEL_AT     = 3'd4;

  // status codes
  localparam logic [1:0] STAT_DONE      = 2'd0;
  localparam logic [1:0] STAT_RANGE     = 2'd1;
  localparam logic [1:0] STAT_FULL      = 2'd2;

  localparam logic signed [31:0] MinusOne = -32'sd1;

  typedef struct packed {
    logic [2:0]         command;
    logic signed [11:0] index;
    logic signed [31:0] value;
  } ili_in_t;

  typedef struct packed {
    logic signed [31:0] read_value;
    logic [1:0]         status;
    logic [10:0]        length;
  } ili_out_t;

  // broadcast control for every cell of the row
  typedef struct packed {
    logic ins;   // shift up from pos, place new value at pos
    logic del;   // shift down from pos
    logic cap;   // snapshot value into the read line
    logic walk;  // read line moves one cell toward cell 0
  } ili_cell_ctl_t;

endpackage

@@ sv/ili_cell.sv @@
// ili_cell: one storage cell of the list row, holds one entry and one read line tap
// depends on ili_pkg
`timescale 1ns / 1ps

module ili_cell #(
  parameter int unsigned PW  = 10,
  parameter int unsigned IDX = 0
) (
  input  logic                   clk_i,
  input  ili_pkg::ili_cell_ctl_t ctl_i,
  input  logic [PW-1:0]          pos_i,
  input  logic signed [31:0]     new_i,
  input  logic signed [31:0]     value_lo_i,
  input  logic signed [31:0]     value_hi_i,
  input  logic signed [31:0]     rd_hi_i,
  output logic signed [31:0]     value_o,
  output logic signed [31:0]     rd_o
);
  import ili_pkg::*;

  localparam logic [PW-1:0] MyPos = PW'(IDX);

  logic signed [31:0] value_q, value_d;
  logic signed [31:0] rd_q, rd_d;

  always_comb begin
    value_d = value_q;
    if (ctl_i.ins) begin
      if (MyPos > pos_i) begin
        value_d = value_lo_i;
      end else if (MyPos == pos_i) begin
        value_d = new_i;
      end
    end else if (ctl_i.del && (MyPos >= pos_i)) begin
      value_d = value_hi_i;
    end
  end

  always_comb begin
    rd_d = rd_q;
    if (ctl_i.cap) begin
      rd_d = value_q;
    end else if (ctl_i.walk) begin
      rd_d = rd_hi_i;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    rd_q    <= rd_d;
  end

  assign value_o = value_q;
  assign rd_o    = rd_q;

endmodule

@@ sv/ili_row.sv @@
// ili_row: the row of list cells, wired neighbor to neighbor
// depends on ili_pkg and ili_cell
`timescale 1ns / 1ps

module ili_row #(
  parameter int unsigned CAPACITY = ili_pkg::CapacityDefault,
  parameter int unsigned PW       = 10
) (
  input  logic                   clk_i,
  input  ili_pkg::ili_cell_ctl_t ctl_i,
  input  logic [PW-1:0]          pos_i,
  input  logic signed [31:0]     new_i,
  output logic signed [31:0]     rd0_o
);
  import ili_pkg::*;

  logic signed [31:0] val [CAPACITY];
  logic signed [31:0] rd  [CAPACITY];

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic signed [31:0] lo, hi, rd_hi;

    if (g == 0) begin : g_bottom
      assign lo = val[0];
    end else begin : g_lo
      assign lo = val[g-1];
    end

    if (g == CAPACITY - 1) begin : g_top
      assign hi    = val[g];
      assign rd_hi = rd[g];
    end else begin : g_hi
      assign hi    = val[g+1];
      assign rd_hi = rd[g+1];
    end

    ili_cell #(
      .PW  (PW),
      .IDX (g)
    ) u_cell (
      .clk_i      (clk_i),
      .ctl_i      (ctl_i),
      .pos_i      (pos_i),
      .new_i      (new_i),
      .value_lo_i (lo),
      .value_hi_i (hi),
      .rd_hi_i    (rd_hi),
      .value_o    (val[g]),
      .rd_o       (rd[g])
    );
  end

  assign rd0_o = rd[0];

endmodule

@@ sv/indexed_list_insert_delete.sv @@
// indexed_list_insert_delete: positional list of signed 32-bit entries in a shifting cell row
// depends on ili_pkg and ili_row; results leave through a two-word output queue
`timescale 1ns / 1ps

// Each accepted word gives exactly one result word. Accepted inserts and deletes
// update the row in the cycle they are accepted, rejected commands and unused
// codes leave it as it is, and the next word can follow unless the output queue
// is full. A read of entry k snapshots the whole row into a read line that moves
// one cell per cycle toward cell 0; the block is busy until entry k reaches cell 0,
// and the result word is then pushed into the output queue. The queue holds two
// results, so new words are taken while a result waits for the far side. Entries
// hold no reset value; only positions below the entry count are ever returned.
module indexed_list_insert_delete #(
  parameter int unsigned CAPACITY = ili_pkg::CapacityDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  ili_pkg::ili_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output ili_pkg::ili_out_t out_data_o
);
  import ili_pkg::*;

  localparam int unsigned PW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned KW = (CW > 11) ? CW : 11;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_WALK = 1'b1;

  logic          state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [PW-1:0] walk_q, walk_d;

  logic          in_acc;
  logic          idx_neg, in_range, above, full;
  logic [KW-1:0] idx_k, count_k;

  ili_cell_ctl_t      ctl;
  logic [PW-1:0]      pos;
  logic signed [31:0] rd0;

  logic     push, pop;
  ili_out_t push_data;
  ili_out_t slot_q [2];
  logic     wp_q, rp_q;
  logic [1:0] fifo_cnt_q;

  assign in_stall_o = (state_q != S_IDLE) || (fifo_cnt_q == 2'd2);
  assign in_acc     = in_valid_i && !in_stall_o;

  assign idx_neg  = in_data_i.index[11];
  assign idx_k    = KW'(in_data_i.index[10:0]);
  assign count_k  = KW'(count_q);
  assign in_range = !idx_neg && (idx_k < count_k);
  assign above    = !idx_neg && (idx_k > count_k);
  assign full     = (count_q == CW'(CAPACITY));

  always_comb begin
    ctl                  = '0;
    pos                  = '0;
    count_d              = count_q;
    state_d              = state_q;
    walk_d               = walk_q;
    push                 = 1'b0;
    push_data.read_value = MinusOne;
    push_data.status     = STAT_DONE;
    push_data.length     = 11'(count_q);

    if (state_q == S_WALK) begin
      if (walk_q == '0) begin
        push                 = 1'b1;
        push_data.read_value = rd0;
        state_d              = S_IDLE;
      end else begin
        ctl.walk = 1'b1;
        walk_d   = walk_q - 1'b1;
      end
    end else if (in_acc) begin
      unique case (in_data_i.command) inside
        CMD_READ: begin
          if (in_range) begin
            ctl.cap = 1'b1;
            walk_d  = PW'(in_data_i.index[10:0]);
            state_d = S_WALK;
          end else begin
            push             = 1'b1;
            push_data.status = STAT_RANGE;
          end
        end
        CMD_INS_HEAD, CMD_INS_TAIL: begin
          push = 1'b1;
          if (full) begin
            push_data.status = STAT_FULL;
          end else begin
            ctl.ins = 1'b1;
            pos     = (in_data_i.command == CMD_INS_TAIL) ? PW'(count_q) : '0;
            count_d = count_q + 1'b1;
          end
        end
        CMD_INS_AT: begin
          push = 1'b1;
          if (above) begin
            push_data.status = STAT_RANGE;
          end else if (full) begin
            push_data.status = STAT_FULL;
          end else begin
            ctl.ins = 1'b1;
            pos     = idx_neg ? '0 : PW'(in_data_i.index[10:0]);
            count_d = count_q + 1'b1;
          end
        end
        CMD_DEL_AT: begin
          push = 1'b1;
          if (in_range) begin
            ctl.del = 1'b1;
            pos     = PW'(in_data_i.index[10:0]);
            count_d = count_q - 1'b1;
          end else begin
            push_data.status = STAT_RANGE;
          end
        end
        default: begin
          push = 1'b1;
        end
      endcase
      push_data.length = 11'(count_d);
    end
  end

  ili_row #(
    .CAPACITY (CAPACITY),
    .PW       (PW)
  ) u_row (
    .clk_i (clk_i),
    .ctl_i (ctl),
    .pos_i (pos),
    .new_i (in_data_i.value),
    .rd0_o (rd0)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      walk_q  <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      walk_q  <= walk_d;
    end
  end

  // two-word output queue
  assign out_valid_o = (fifo_cnt_q != 2'd0);
  assign out_data_o  = slot_q[rp_q];
  assign pop         = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wp_q] <= push_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q       <= 1'b0;
      rp_q       <= 1'b0;
      fifo_cnt_q <= 2'd0;
    end else begin
      if (push) begin
        wp_q <= ~wp_q;
      end
      if (pop) begin
        rp_q <= ~rp_q;
      end
      case ({push, pop})
        2'b10:   fifo_cnt_q <= fifo_cnt_q + 2'd1;
        2'b01:   fifo_cnt_q <= fifo_cnt_q - 2'd1;
        default: fifo_cnt_q <= fifo_cnt_q;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push && !pop && (fifo_cnt_q == 2'd2)))
    else $error("result pushed into a full output queue");

  a_walk_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK) |-> in_stall_o)
    else $error("word accepted during a read walk");

  a_ins_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.ins |=> (count_q == $past(count_q) + 1'b1))
    else $error("insert did not grow the list");

endmodule
